### design/bba_pkg.sv
// Shared types, constants and helpers for the buddy bitmap allocator.
// No dependencies; used by bba_ctrl, bba_dp and buddy_bitmap_allocator.
package bba_pkg;

  localparam int MaxDepth    = 16;
  localparam int HeaderBytes = 4;
  localparam int MinBucket   = 8;

  localparam int IdxW      = 17;
  localparam int SizeW     = 29;
  localparam int LvlW      = 5;
  localparam int BucketW   = 13;
  localparam int WordW     = 32;
  localparam int WordBits  = 5;
  localparam int WordAddrW = IdxW - WordBits;
  localparam int NumWords  = 1 << WordAddrW;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_ZERO   = 3'd1,
    ST_LARGE  = 3'd2,
    ST_NOFREE = 3'd3,
    ST_BAD    = 3'd4,
    ST_DOUBLE = 3'd5
  } bba_status_e;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [SizeW-1:0] request_size;
    logic [IdxW-1:0]  block_index;
    logic [SizeW-1:0] user_offset;
  } bba_req_t;

  typedef struct packed {
    bba_status_e      status;
    logic [IdxW-1:0]  granted_index;
    logic [SizeW-1:0] granted_offset;
    logic [LvlW-1:0]  granted_level;
  } bba_rsp_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_LEVEL,
    OP_NODE_LVL,
    OP_MUL,
    OP_SCAN_SET,
    OP_SCAN_CHK,
    OP_WRITE,
    OP_ANC_INIT,
    OP_UP,
    OP_SUB_INIT,
    OP_SUB_NEXT,
    OP_BUDDY,
    OP_CLEAR,
    OP_RESULT
  } bba_op_e;

  typedef struct packed {
    bba_op_e     op;
    bba_status_e status;
    logic        grant;
  } bba_cmd_t;

  typedef struct packed {
    logic alloc;
    logic zero_size;
    logic too_large;
    logic lvl_done;
    logic scan_hit;
    logic range_last;
    logic bit_set;
    logic bad_free;
    logic cur_root;
    logic sub_last;
    logic clr_done;
  } bba_sts_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_LEVEL,
    S_SCWAIT,
    S_SCCHK,
    S_ANC,
    S_AWAIT,
    S_AWR,
    S_AUP,
    S_ASUB,
    S_FMUL,
    S_FCHK,
    S_FWAIT,
    S_FBIT,
    S_SWAIT,
    S_SWR,
    S_SUBEND,
    S_AMUL,
    S_ARES,
    S_MROOT,
    S_MWAIT,
    S_MCHK,
    S_PWAIT,
    S_PWR
  } bba_state_e;

  // first node index of a level: 2^lvl - 1
  function automatic logic [IdxW:0] level_first(input logic [LvlW-1:0] lvl);
    level_first = ((IdxW+1)'(1) << lvl) - (IdxW+1)'(1);
  endfunction

endpackage

### design/bba_ctrl.sv
// Sequencer for the buddy bitmap allocator: clear pass, level search,
// ancestor/subtree marking and free merging. Depends on bba_pkg.
module bba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  bba_pkg::bba_sts_t sts_i,
  output bba_pkg::bba_cmd_t cmd_o
);

  bba_pkg::bba_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bba_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o.op     = bba_pkg::OP_NONE;
    cmd_o.status = bba_pkg::ST_OK;
    cmd_o.grant  = 1'b0;
    busy_o       = (state_q != bba_pkg::S_IDLE);
    unique case (state_q)
      bba_pkg::S_CLEAR: begin
        cmd_o.op = bba_pkg::OP_CLEAR;
        if (sts_i.clr_done) state_d = bba_pkg::S_IDLE;
      end
      bba_pkg::S_IDLE: begin
        if (start_i) begin
          cmd_o.op = bba_pkg::OP_LOAD;
          state_d  = bba_pkg::S_DECODE;
        end
      end
      bba_pkg::S_DECODE: begin
        if (sts_i.alloc) begin
          if (sts_i.zero_size) begin
            cmd_o.op     = bba_pkg::OP_RESULT;
            cmd_o.status = bba_pkg::ST_ZERO;
            state_d      = bba_pkg::S_IDLE;
          end else if (sts_i.too_large) begin
            cmd_o.op     = bba_pkg::OP_RESULT;
            cmd_o.status = bba_pkg::ST_LARGE;
            state_d      = bba_pkg::S_IDLE;
          end else begin
            state_d = bba_pkg::S_LEVEL;
          end
        end else begin
          cmd_o.op = bba_pkg::OP_NODE_LVL;
          state_d  = bba_pkg::S_FMUL;
        end
      end
      bba_pkg::S_LEVEL: begin
        if (sts_i.lvl_done) begin
          cmd_o.op = bba_pkg::OP_SCAN_SET;
          state_d  = bba_pkg::S_SCWAIT;
        end else begin
          cmd_o.op = bba_pkg::OP_LEVEL;
        end
      end
      bba_pkg::S_SCWAIT: state_d = bba_pkg::S_SCCHK;
      bba_pkg::S_SCCHK: begin
        cmd_o.op = bba_pkg::OP_SCAN_CHK;
        if (sts_i.scan_hit) begin
          state_d = bba_pkg::S_ANC;
        end else if (sts_i.range_last) begin
          cmd_o.op     = bba_pkg::OP_RESULT;
          cmd_o.status = bba_pkg::ST_NOFREE;
          state_d      = bba_pkg::S_IDLE;
        end else begin
          state_d = bba_pkg::S_SCWAIT;
        end
      end
      bba_pkg::S_ANC: begin
        cmd_o.op = bba_pkg::OP_ANC_INIT;
        state_d  = bba_pkg::S_AWAIT;
      end
      bba_pkg::S_AWAIT: state_d = bba_pkg::S_AWR;
      bba_pkg::S_AWR: begin
        cmd_o.op = bba_pkg::OP_WRITE;
        state_d  = sts_i.cur_root ? bba_pkg::S_ASUB : bba_pkg::S_AUP;
      end
      bba_pkg::S_AUP: begin
        cmd_o.op = bba_pkg::OP_UP;
        state_d  = bba_pkg::S_AWAIT;
      end
      bba_pkg::S_ASUB: begin
        cmd_o.op = bba_pkg::OP_SUB_INIT;
        state_d  = bba_pkg::S_SWAIT;
      end
      bba_pkg::S_FMUL: begin
        cmd_o.op = bba_pkg::OP_MUL;
        state_d  = bba_pkg::S_FCHK;
      end
      bba_pkg::S_FCHK: begin
        if (sts_i.bad_free) begin
          cmd_o.op     = bba_pkg::OP_RESULT;
          cmd_o.status = bba_pkg::ST_BAD;
          state_d      = bba_pkg::S_IDLE;
        end else begin
          cmd_o.op = bba_pkg::OP_SUB_INIT;
          state_d  = bba_pkg::S_FWAIT;
        end
      end
      bba_pkg::S_FWAIT: state_d = bba_pkg::S_FBIT;
      bba_pkg::S_FBIT: begin
        if (!sts_i.bit_set) begin
          cmd_o.op     = bba_pkg::OP_RESULT;
          cmd_o.status = bba_pkg::ST_DOUBLE;
          state_d      = bba_pkg::S_IDLE;
        end else begin
          cmd_o.op = bba_pkg::OP_WRITE;
          state_d  = sts_i.range_last ? bba_pkg::S_SUBEND : bba_pkg::S_SWAIT;
        end
      end
      bba_pkg::S_SWAIT: state_d = bba_pkg::S_SWR;
      bba_pkg::S_SWR: begin
        cmd_o.op = bba_pkg::OP_WRITE;
        state_d  = sts_i.range_last ? bba_pkg::S_SUBEND : bba_pkg::S_SWAIT;
      end
      bba_pkg::S_SUBEND: begin
        if (!sts_i.sub_last) begin
          cmd_o.op = bba_pkg::OP_SUB_NEXT;
          state_d  = bba_pkg::S_SWAIT;
        end else if (sts_i.alloc) begin
          state_d = bba_pkg::S_AMUL;
        end else begin
          cmd_o.op = bba_pkg::OP_ANC_INIT;
          state_d  = bba_pkg::S_MROOT;
        end
      end
      bba_pkg::S_AMUL: begin
        cmd_o.op = bba_pkg::OP_MUL;
        state_d  = bba_pkg::S_ARES;
      end
      bba_pkg::S_ARES: begin
        cmd_o.op    = bba_pkg::OP_RESULT;
        cmd_o.grant = 1'b1;
        state_d     = bba_pkg::S_IDLE;
      end
      bba_pkg::S_MROOT: begin
        if (sts_i.cur_root) begin
          cmd_o.op = bba_pkg::OP_RESULT;
          state_d  = bba_pkg::S_IDLE;
        end else begin
          cmd_o.op = bba_pkg::OP_BUDDY;
          state_d  = bba_pkg::S_MWAIT;
        end
      end
      bba_pkg::S_MWAIT: state_d = bba_pkg::S_MCHK;
      bba_pkg::S_MCHK: begin
        if (sts_i.bit_set) begin
          cmd_o.op = bba_pkg::OP_RESULT;
          state_d  = bba_pkg::S_IDLE;
        end else begin
          cmd_o.op = bba_pkg::OP_UP;
          state_d  = bba_pkg::S_PWAIT;
        end
      end
      bba_pkg::S_PWAIT: state_d = bba_pkg::S_PWR;
      bba_pkg::S_PWR: begin
        cmd_o.op = bba_pkg::OP_WRITE;
        state_d  = bba_pkg::S_MROOT;
      end
      default: state_d = bba_pkg::S_IDLE;
    endcase
  end

endmodule

### design/bba_dp.sv
// Datapath of the buddy bitmap allocator: the node bitmap in 32-bit words,
// range masking, level and offset arithmetic, result word. Depends on bba_pkg.
module bba_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [bba_pkg::LvlW-1:0]     split_levels_i,
  input  logic [bba_pkg::BucketW-1:0]  leaf_bytes_i,
  input  bba_pkg::bba_req_t            req_i,
  input  bba_pkg::bba_cmd_t            cmd_i,
  output bba_pkg::bba_sts_t            sts_o,
  output logic                         done_o,
  output bba_pkg::bba_rsp_t            rsp_o
);

  localparam int IdxW  = bba_pkg::IdxW;
  localparam int SizeW = bba_pkg::SizeW;
  localparam int LvlW  = bba_pkg::LvlW;
  localparam int WW    = bba_pkg::WordW;
  localparam int WB    = bba_pkg::WordBits;
  localparam int AW    = bba_pkg::WordAddrW;

  logic [WW-1:0] mem_q [bba_pkg::NumWords];
  logic [WW-1:0] rdata_q;

  logic             op_q;
  logic [SizeW-1:0] req_q, uoff_q, bsize_q, prod_q;
  logic [IdxW-1:0]  idx_q, cur_q, lo_q, hi_q;
  logic [LvlW-1:0]  lvl_q, dlvl_q;
  logic [AW-1:0]    ptr_q, clr_q;
  logic             done_q;
  bba_pkg::bba_rsp_t rsp_q;

  logic [LvlW-1:0]            lv, node_lvl, shamt;
  logic [bba_pkg::BucketW-1:0] bucket;
  logic [SizeW-1:0]           area;
  logic [SizeW:0]             total, offset;
  logic [IdxW:0]              nodes, v, first_cur, last_cur;
  logic [15:0]                pos;
  logic [WW-1:0]              lomask, himask, rmask, masked, wdata;
  logic [WB-1:0]              zpos;
  logic [IdxW-1:0]            buddy, parent, nlo, nhi;
  logic                       we;
  logic [AW-1:0]              waddr;

  assign lv     = (split_levels_i > LvlW'(bba_pkg::MaxDepth)) ? LvlW'(bba_pkg::MaxDepth)
                                                               : split_levels_i;
  assign bucket = (leaf_bytes_i < bba_pkg::BucketW'(bba_pkg::MinBucket))
                  ? bba_pkg::BucketW'(bba_pkg::MinBucket) : leaf_bytes_i;
  assign area   = SizeW'(bucket) << lv;
  assign total  = (SizeW+1)'(req_q) + (SizeW+1)'(bba_pkg::HeaderBytes);
  assign nodes  = ((IdxW+1)'(2) << lv) - (IdxW+1)'(1);
  assign v      = (IdxW+1)'(idx_q) + (IdxW+1)'(1);

  always_comb begin
    node_lvl = '0;
    for (int i = 0; i <= IdxW; i++) begin
      if (v[i]) node_lvl = LvlW'(i);
    end
  end

  assign first_cur = bba_pkg::level_first(lvl_q);
  assign last_cur  = bba_pkg::level_first(lvl_q + LvlW'(1)) - (IdxW+1)'(1);
  assign pos       = 16'((IdxW+1)'(idx_q) - first_cur);
  assign shamt     = lv - lvl_q;
  assign offset    = ((SizeW+1)'(prod_q) << shamt) + (SizeW+1)'(bba_pkg::HeaderBytes);

  // bits of the current word that fall inside [lo, hi]
  assign lomask = {WW{1'b1}} << lo_q[WB-1:0];
  assign himask = {WW{1'b1}} >> (WB'(WW - 1) - hi_q[WB-1:0]);
  assign rmask  = ((ptr_q == lo_q[IdxW-1:WB]) ? lomask : {WW{1'b1}})
                & ((ptr_q == hi_q[IdxW-1:WB]) ? himask : {WW{1'b1}});
  assign masked = rdata_q | ~rmask;

  always_comb begin
    zpos = '0;
    for (int b = WW - 1; b >= 0; b--) begin
      if (!masked[b]) zpos = WB'(b);
    end
  end

  assign buddy  = cur_q[0] ? cur_q + IdxW'(1) : cur_q - IdxW'(1);
  assign parent = (cur_q - IdxW'(1)) >> 1;
  assign nlo    = {lo_q[IdxW-2:0], 1'b1};
  assign nhi    = {hi_q[IdxW-2:0], 1'b0} + IdxW'(2);

  always_comb begin
    we    = 1'b0;
    waddr = ptr_q;
    wdata = (op_q == bba_pkg::OpFree) ? (rdata_q & ~rmask) : (rdata_q | rmask);
    if (cmd_i.op == bba_pkg::OP_CLEAR) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = '0;
    end else if (cmd_i.op == bba_pkg::OP_WRITE) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      clr_q  <= '0;
    end else begin
      done_q <= (cmd_i.op == bba_pkg::OP_RESULT);
      if (cmd_i.op == bba_pkg::OP_CLEAR) clr_q <= clr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      bba_pkg::OP_LOAD: begin
        op_q    <= req_i.operation;
        req_q   <= req_i.request_size;
        idx_q   <= req_i.block_index;
        uoff_q  <= req_i.user_offset;
        lvl_q   <= lv;
        bsize_q <= SizeW'(bucket);
      end
      bba_pkg::OP_LEVEL: begin
        bsize_q <= bsize_q << 1;
        lvl_q   <= lvl_q - LvlW'(1);
      end
      bba_pkg::OP_NODE_LVL: lvl_q <= node_lvl;
      bba_pkg::OP_MUL:      prod_q <= SizeW'(pos) * SizeW'(bucket);
      bba_pkg::OP_SCAN_SET: begin
        lo_q  <= IdxW'(first_cur);
        hi_q  <= IdxW'(last_cur);
        ptr_q <= first_cur[IdxW-1:WB];
      end
      bba_pkg::OP_SCAN_CHK: begin
        if (~&masked) idx_q <= {ptr_q, zpos};
        else          ptr_q <= ptr_q + AW'(1);
      end
      bba_pkg::OP_WRITE: ptr_q <= ptr_q + AW'(1);
      bba_pkg::OP_ANC_INIT: begin
        cur_q <= idx_q;
        lo_q  <= idx_q;
        hi_q  <= idx_q;
        ptr_q <= idx_q[IdxW-1:WB];
      end
      bba_pkg::OP_UP: begin
        cur_q <= parent;
        lo_q  <= parent;
        hi_q  <= parent;
        ptr_q <= parent[IdxW-1:WB];
      end
      bba_pkg::OP_SUB_INIT: begin
        lo_q   <= idx_q;
        hi_q   <= idx_q;
        dlvl_q <= lvl_q;
        ptr_q  <= idx_q[IdxW-1:WB];
      end
      bba_pkg::OP_SUB_NEXT: begin
        lo_q   <= nlo;
        hi_q   <= nhi;
        dlvl_q <= dlvl_q + LvlW'(1);
        ptr_q  <= nlo[IdxW-1:WB];
      end
      bba_pkg::OP_BUDDY: begin
        lo_q  <= buddy;
        hi_q  <= buddy;
        ptr_q <= buddy[IdxW-1:WB];
      end
      bba_pkg::OP_RESULT: begin
        rsp_q.status <= cmd_i.status;
        if (cmd_i.grant) begin
          rsp_q.granted_index  <= idx_q;
          rsp_q.granted_offset <= offset[SizeW-1:0];
          rsp_q.granted_level  <= lvl_q;
        end else begin
          rsp_q.granted_index  <= '0;
          rsp_q.granted_offset <= '0;
          rsp_q.granted_level  <= '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    sts_o.alloc      = (op_q == bba_pkg::OpAlloc);
    sts_o.zero_size  = (req_q == '0);
    sts_o.too_large  = (total > (SizeW+1)'(area));
    sts_o.lvl_done   = !(((SizeW+1)'(bsize_q) < total) && (lvl_q != '0));
    sts_o.scan_hit   = ~&masked;
    sts_o.range_last = (ptr_q == hi_q[IdxW-1:WB]);
    sts_o.bit_set    = rdata_q[lo_q[WB-1:0]];
    sts_o.bad_free   = ((IdxW+1)'(idx_q) >= nodes) || (offset != (SizeW+1)'(uoff_q));
    sts_o.cur_root   = (cur_q == '0);
    sts_o.sub_last   = (dlvl_q == lv);
    sts_o.clr_done   = &clr_q;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for more than one cycle");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && rsp_q.status != bba_pkg::ST_OK) |->
      (rsp_q.granted_index == '0 && rsp_q.granted_offset == '0 &&
       rsp_q.granted_level == '0))
    else $error("grant fields not zero on an error");

  a_lvl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rsp_q.granted_level <= LvlW'(bba_pkg::MaxDepth)))
    else $error("granted level beyond the deepest level");

endmodule

### design/buddy_bitmap_allocator.sv
// Buddy allocator over a heap-ordered node bitmap: configuration registers,
// sequencer and datapath. Depends on bba_pkg, bba_ctrl and bba_dp.
//
// Use: drive req_i and pulse start while busy is low; the word is taken at
// that edge. One result word per request appears on rsp_o for exactly one
// cycle with done_o high; the receiver cannot stall it and must take it then.
// Allocate: decode, up to 16 level steps, a scan of the bitmap words of the
// target level, marking of each node from the block up to the root, then
// marking of the subtree word by word and level by level. Free: decode, an
// offset check, a bit check and clearing of the subtree, then merge steps
// toward the root. Every bitmap access is a registered read followed by a
// write on the bitmap memory. A zero or oversized request answers from
// decode, a bad free after the offset check, a double free at the bit check.
// One request at a time; busy stays high until the result cycle.
// After reset a clearing pass zeroes the 4096-word bitmap, one word a cycle,
// with busy high; APB writes are taken throughout.
// APB: split level count at 0x0, leaf block bytes at 0x4; write only while idle.
module buddy_bitmap_allocator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  bba_pkg::bba_req_t                  req_i,
  output logic                               done_o,
  output bba_pkg::bba_rsp_t                  rsp_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic [bba_pkg::LvlW-1:0]    split_levels_q;
  logic [bba_pkg::BucketW-1:0] min_bucket_q;
  bba_pkg::bba_cmd_t           cmd;
  bba_pkg::bba_sts_t           sts;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_levels_q <= bba_pkg::LvlW'(10);
      min_bucket_q   <= bba_pkg::BucketW'(8);
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) min_bucket_q   <= pwdata[bba_pkg::BucketW-1:0];
      else          split_levels_q <= pwdata[bba_pkg::LvlW-1:0];
    end
  end

  assign prdata = paddr[2] ? {{(32 - bba_pkg::BucketW){1'b0}}, min_bucket_q}
                           : {{(32 - bba_pkg::LvlW){1'b0}}, split_levels_q};

  bba_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  bba_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .split_levels_i (split_levels_q),
    .leaf_bytes_i   (min_bucket_q),
    .req_i          (req_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .done_o         (done_o),
    .rsp_o          (rsp_o)
  );

endmodule
